/* hdl/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the byte-serial UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned LEN_W   = 3;

    // Stream data widths, padded to whole bytes
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 24;

    // Replacement character for malformed input
    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

    // Sequence lengths
    localparam logic [LEN_W-1:0] LEN_IDLE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THR  = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    // One decoded result on its way to the output register
    typedef struct packed {
        logic                valid;
        logic [CP_W-1:0]     code_point;
        logic [COUNT_W-1:0]  byte_count;
        logic                invalid;
    } t_result;

endpackage

`default_nettype wire

/* hdl/utf8d_in_reg.sv */
// ----------------------------------------------------------------------------
// utf8d_in_reg
// Input register: captures one byte per transfer and hands it to the decoder
// core when the pipeline advances.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_in_reg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [utf8d_pkg::BYTE_W-1:0]  i_s_tdata,   // [7:0] in_byte
    input  wire logic                          i_advance,
    output logic                               o_valid,
    output logic [utf8d_pkg::BYTE_W-1:0]       o_byte
);

    logic                         r_valid;
    logic [utf8d_pkg::BYTE_W-1:0] r_byte;

    // Free when empty or when the held byte moves on this cycle
    assign o_s_tready = !r_valid || i_advance;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_byte <= i_s_tdata;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

/* hdl/utf8d_core.sv */
// ----------------------------------------------------------------------------
// utf8d_core
// Decoder state (sequence length, bytes taken, accumulator) and the combinational
// decode of the current byte into an optional result.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [utf8d_pkg::BYTE_W-1:0]  i_byte,
    output utf8d_pkg::t_result                 o_result
);

    logic [utf8d_pkg::LEN_W-1:0]   r_exp_len, n_exp_len;
    logic [utf8d_pkg::LEN_W-1:0]   r_seen,    n_seen;
    logic [utf8d_pkg::CP_W-1:0]    r_acc,     n_acc;

    logic                          seq_open;
    logic [utf8d_pkg::LEN_W-1:0]   seen;
    logic [utf8d_pkg::LEN_W-1:0]   diff;
    logic [utf8d_pkg::CP_W-1:0]    cont_bits;
    logic [utf8d_pkg::CP_W-1:0]    acc_upd;

    // Only lengths two to four count as an open sequence
    assign seq_open = (r_exp_len >= utf8d_pkg::LEN_TWO) && (r_exp_len <= utf8d_pkg::LEN_FOUR);
    assign seen     = r_seen + utf8d_pkg::LEN_ONE;
    assign diff     = (r_exp_len > seen) ? (r_exp_len - seen) : utf8d_pkg::LEN_IDLE;

    // Place the six payload bits of a continuation byte
    always_comb begin
        case (diff)
            3'd1:    cont_bits = {9'd0,  i_byte[5:0], 6'd0};
            3'd2:    cont_bits = {3'd0,  i_byte[5:0], 12'd0};
            3'd3:    cont_bits = {i_byte[2:0], 18'd0};
            default: cont_bits = {15'd0, i_byte[5:0]};
        endcase
    end

    assign acc_upd = r_acc | cont_bits;

    // Decode
    always_comb begin
        n_exp_len           = utf8d_pkg::LEN_IDLE;
        n_seen              = utf8d_pkg::LEN_IDLE;
        n_acc               = '0;
        o_result.valid      = 1'b0;
        o_result.code_point = utf8d_pkg::REPLACEMENT;
        o_result.byte_count = utf8d_pkg::LEN_ONE;
        o_result.invalid    = 1'b0;
        if (!seq_open) begin
            if (!i_byte[7]) begin
                // ASCII passes straight through
                o_result.valid      = 1'b1;
                o_result.code_point = {13'd0, i_byte};
            end else if (i_byte[7:5] == 3'b110) begin
                n_exp_len = utf8d_pkg::LEN_TWO;
                n_seen    = utf8d_pkg::LEN_ONE;
                n_acc     = {10'd0, i_byte[4:0], 6'd0};
            end else if (i_byte[7:4] == 4'b1110) begin
                n_exp_len = utf8d_pkg::LEN_THR;
                n_seen    = utf8d_pkg::LEN_ONE;
                n_acc     = {5'd0, i_byte[3:0], 12'd0};
            end else if (i_byte[7:3] == 5'b11110) begin
                n_exp_len = utf8d_pkg::LEN_FOUR;
                n_seen    = utf8d_pkg::LEN_ONE;
                n_acc     = {i_byte[2:0], 18'd0};
            end else begin
                // Stray continuation or illegal lead
                o_result.valid   = 1'b1;
                o_result.invalid = 1'b1;
            end
        end else if (i_byte[7:6] != 2'b10) begin
            // Broken sequence: the offending byte is swallowed
            o_result.valid      = 1'b1;
            o_result.invalid    = 1'b1;
            o_result.byte_count = seen;
        end else if (seen >= r_exp_len) begin
            o_result.valid      = 1'b1;
            o_result.code_point = acc_upd;
            o_result.byte_count = r_exp_len;
        end else begin
            n_exp_len = r_exp_len;
            n_seen    = seen;
            n_acc     = acc_upd;
        end
    end

    // Sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len <= utf8d_pkg::LEN_IDLE;
            r_seen    <= utf8d_pkg::LEN_IDLE;
            r_acc     <= '0;
        end else if (i_step) begin
            r_exp_len <= n_exp_len;
            r_seen    <= n_seen;
            r_acc     <= n_acc;
        end
    end

endmodule

`default_nettype wire

/* hdl/utf8d_out_reg.sv */
// ----------------------------------------------------------------------------
// utf8d_out_reg
// Result register: holds one decoded code point until the downstream side
// takes the transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_out_reg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_load,
    input  wire utf8d_pkg::t_result              i_result,
    output logic                                 o_advance,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [utf8d_pkg::M_TDATA_W-1:0]      o_m_tdata,  // [20:0] code_point, [23:21] byte_count
    output logic [0:0]                           o_m_tuser   // [0] invalid
);

    logic                              r_valid;
    logic [utf8d_pkg::CP_W-1:0]        r_cp;
    logic [utf8d_pkg::COUNT_W-1:0]     r_count;
    logic                              r_invalid;

    // Register may take a new result when empty or being drained
    assign o_advance = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load && i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load && i_result.valid) begin
            r_cp      <= i_result.code_point;
            r_count   <= i_result.byte_count;
            r_invalid <= i_result.invalid;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_count, r_cp};
    assign o_m_tuser  = r_invalid;

endmodule

`default_nettype wire

/* hdl/utf8_stream_decoder_top.sv */
// A completing byte passes from the input register through the combinational decode into the result register.
// Throughput: one byte per cycle while the result side is ready; the decode is a single pass between the input
// register and the result register.
// Back-pressure from the result side stalls both registers together.
// Reset (synchronous, active low) empties both registers and closes any open sequence.
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Byte-serial UTF-8 decoder with stream interfaces on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [utf8d_pkg::S_TDATA_W-1:0] i_s_tdata,  // [7:0] in_byte
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [utf8d_pkg::M_TDATA_W-1:0]      o_m_tdata,  // [20:0] code_point, [23:21] byte_count
    output logic [0:0]                           o_m_tuser   // [0] invalid
);

    logic                          advance;
    logic                          in_valid;
    logic [utf8d_pkg::BYTE_W-1:0]  in_byte;
    logic                          step;
    utf8d_pkg::t_result            result;

    assign step = in_valid && advance;

    utf8d_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_advance  (advance),
        .o_valid    (in_valid),
        .o_byte     (in_byte)
    );

    utf8d_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (in_byte),
        .o_result (result)
    );

    utf8d_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_valid),
        .i_result   (result),
        .o_advance  (advance),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // A flagged result always carries the replacement character
    a_invalid_is_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[20:0] == utf8d_pkg::REPLACEMENT)
        else $error("invalid result without replacement character");

    // Byte count stays within one to four
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[23:21] >= 3'd1 && o_m_tdata[23:21] <= 3'd4)
        else $error("byte count out of range");

    // A good single-byte result is plain ASCII
    a_single_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] && o_m_tdata[23:21] == 3'd1
        |-> o_m_tdata[20:7] == 14'd0)
        else $error("single-byte result above ASCII range");

    // A held byte is not lost while the result side is stalled
    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && !advance |=> in_valid && $stable(in_byte))
        else $error("held input byte dropped during stall");

endmodule

`default_nettype wire
